// File: rtl/core/mbhw_pkg.sv
// ----------------------------------------------------------------------------
// mbhw_pkg
// Types and constants shared by the MP4 box header walker.
// ----------------------------------------------------------------------------
package mbhw_pkg;

  localparam int OFFSET_W = 48;
  localparam int WORD_W   = 32;

  localparam logic [WORD_W-1:0]   TYPE_MOOF = 32'h6D6F_6F66;
  localparam logic [WORD_W-1:0]   TYPE_TRAF = 32'h7472_6166;
  localparam logic [WORD_W-1:0]   TYPE_MDAT = 32'h6D64_6174;
  localparam logic [OFFSET_W-1:0] MIN_TAIL  = 48'd9;
  localparam logic [WORD_W-1:0]   HDR_LEN   = 32'd8;

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;

  typedef enum logic [1:0] {
    MODE_HEADER = 2'd0,
    MODE_MDAT   = 2'd1,
    MODE_SKIP   = 2'd2
  } walk_mode_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [WORD_W-1:0]   type_code;
    logic [WORD_W-1:0]   declared_size;
    logic [OFFSET_W-1:0] box_offset;
    logic [7:0]          payload_byte;
    logic                last_payload;
    logic                short_size;
  } result_t;

endpackage

// File: rtl/core/mp4_box_header_walker.sv
// ----------------------------------------------------------------------------
// mp4_box_header_walker
// Walks ISO BMFF box headers in a byte stream, one byte per clock.
// ----------------------------------------------------------------------------
// Takes one file byte per cycle and reports each 8-byte box header (size,
// type, offset), passes mdat payload bytes through with a last flag, descends
// into moof and traf, and skips the payload of every other box. Once a byte
// lands on a box boundary at or beyond total_length minus 9, one end request
// is issued and all later bytes are dropped. The walk logic sits between the
// input handshake and a two-deep result buffer, so a byte is taken every
// cycle while the buffer has room; a stalled consumer holds in_ready low only
// after two results are waiting. total_length must be written while the block
// is idle, a rule the block itself leaves to the user; a value below 9 turns the end test off.
module mp4_box_header_walker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mbhw_pkg::OFFSET_W-1:0] total_length,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    data_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    kind,
  output logic [mbhw_pkg::WORD_W-1:0]   type_code,
  output logic [mbhw_pkg::WORD_W-1:0]   declared_size,
  output logic [mbhw_pkg::OFFSET_W-1:0] box_offset,
  output logic [7:0]                    payload_byte,
  output logic                          last_payload,
  output logic                          short_size
);
  import mbhw_pkg::*;

  logic                tail_en;
  logic [OFFSET_W-1:0] tail_limit;
  logic [OFFSET_W-1:0] file_offset;
  logic [63:0]         header_bytes;
  logic [2:0]          header_count;
  logic [OFFSET_W-1:0] box_start;
  logic [WORD_W-1:0]   bytes_left;
  walk_mode_t          walk_mode;
  walk_mode_t          walk_mode_next;
  logic                finished;

  result_t             out_res;
  result_t             skid_res;
  logic                skid_valid;

  logic                accept;
  logic                step;
  logic                in_header;
  logic                end_hit;
  logic                hdr_done;
  logic [63:0]         hdr_shift;
  logic [WORD_W-1:0]   new_size;
  logic [WORD_W-1:0]   new_type;
  logic [WORD_W-1:0]   new_len;
  logic                res_valid;
  result_t             res;

  assign cfg_ready = 1'b1;
  assign in_ready  = !skid_valid;
  assign accept    = in_valid && in_ready;
  assign step      = accept && !finished;

  assign in_header = (walk_mode != MODE_MDAT) && (walk_mode != MODE_SKIP);
  assign end_hit   = in_header && (header_count == 3'd0) && tail_en &&
                     (file_offset >= tail_limit);
  assign hdr_done  = in_header && !end_hit && (header_count == 3'd7);
  assign hdr_shift = {header_bytes[55:0], data_byte};
  assign new_size  = hdr_shift[63:32];
  assign new_type  = hdr_shift[31:0];
  assign new_len   = new_size - HDR_LEN;

  always_comb begin
    walk_mode_next = walk_mode;
    unique case (walk_mode)
      MODE_MDAT, MODE_SKIP: begin
        if (bytes_left == 32'd1) walk_mode_next = MODE_HEADER;
      end
      default: begin
        if (hdr_done) begin
          if (new_type == TYPE_MOOF || new_type == TYPE_TRAF || new_len == '0) begin
            walk_mode_next = MODE_HEADER;
          end else if (new_type == TYPE_MDAT) begin
            walk_mode_next = MODE_MDAT;
          end else begin
            walk_mode_next = MODE_SKIP;
          end
        end
      end
    endcase
  end

  always_comb begin
    res_valid = 1'b0;
    res       = '0;
    if (walk_mode == MODE_MDAT) begin
      res_valid         = 1'b1;
      res.kind          = KIND_PAYLOAD;
      res.type_code     = header_bytes[31:0];
      res.declared_size = header_bytes[63:32];
      res.box_offset    = box_start;
      res.payload_byte  = data_byte;
      res.last_payload  = (bytes_left == 32'd1);
      res.short_size    = (header_bytes[63:32] < HDR_LEN);
    end else if (end_hit) begin
      res_valid      = 1'b1;
      res.kind       = KIND_END;
      res.box_offset = file_offset;
    end else if (hdr_done) begin
      res_valid         = 1'b1;
      res.kind          = KIND_HEADER;
      res.type_code     = new_type;
      res.declared_size = new_size;
      res.box_offset    = box_start;
      res.short_size    = (new_size < HDR_LEN);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tail_en      <= 1'b0;
      tail_limit   <= '0;
      file_offset  <= '0;
      header_bytes <= '0;
      header_count <= '0;
      box_start    <= '0;
      bytes_left   <= '0;
      walk_mode    <= MODE_HEADER;
      finished     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        tail_en    <= (total_length >= MIN_TAIL);
        tail_limit <= total_length - MIN_TAIL;
      end
      if (step) begin
        walk_mode <= walk_mode_next;
        if (end_hit) begin
          finished <= 1'b1;
        end else begin
          file_offset <= file_offset + 48'd1;
          if (in_header) begin
            if (header_count == 3'd0) box_start <= file_offset;
            header_bytes <= hdr_shift;
            header_count <= header_count + 3'd1;
            if (hdr_done) bytes_left <= new_len;
          end else begin
            bytes_left <= bytes_left - 32'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && out_ready) begin
      if (skid_valid) begin
        out_res    <= skid_res;
        skid_valid <= 1'b0;
      end else if (step && res_valid) begin
        out_res <= res;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (!out_valid) begin
      if (step && res_valid) begin
        out_res   <= res;
        out_valid <= 1'b1;
      end
    end else if (step && res_valid) begin
      skid_res   <= res;
      skid_valid <= 1'b1;
    end
  end

  assign kind          = out_res.kind;
  assign type_code     = out_res.type_code;
  assign declared_size = out_res.declared_size;
  assign box_offset    = out_res.box_offset;
  assign payload_byte  = out_res.payload_byte;
  assign last_payload  = out_res.last_payload;
  assign short_size    = out_res.short_size;

endmodule

// File: tb/mp4_box_header_walker_tb.sv
// ----------------------------------------------------------------------------
// mp4_box_header_walker_tb
// Self-checking testbench for the MP4 box header walker.
// ----------------------------------------------------------------------------
// Feeds byte streams built from box headers and payloads through the input
// request channel, and predicts every header, mdat payload and end-of-file
// report with a cycle-free model of the walk. Expected reports are queued as
// bytes are taken and checked field by field as the block returns them. A
// short table of boxes covers the size and type extremes and the short-size
// forms. Random boxes follow under several total_length settings. The last
// phase arms the end-of-file test and keeps feeding until it fires.
// ----------------------------------------------------------------------------
module mp4_box_header_walker_tb;
  import mbhw_pkg::*;

  localparam int LIMIT = 400000;

  typedef struct packed {
    logic [WORD_W-1:0]   size;
    logic [WORD_W-1:0]   btype;
    logic [15:0]         plen;
    logic [7:0]          fill;
    logic                short_flag;
    logic [OFFSET_W-1:0] at;
  } box_row_t;

  localparam box_row_t DIR_ROWS [0:7] = '{
    '{32'hFFFF_FFFF, TYPE_MOOF,    16'd0, 8'h00, 1'b0, 48'd0},
    '{32'd0,         TYPE_TRAF,    16'd0, 8'h00, 1'b1, 48'd8},
    '{32'd10,        TYPE_MDAT,    16'd2, 8'hFF, 1'b0, 48'd16},
    '{32'd9,         32'h0000_0000, 16'd1, 8'h00, 1'b0, 48'd26},
    '{32'd8,         32'hFFFF_FFFF, 16'd0, 8'h00, 1'b0, 48'd35},
    '{32'd8,         TYPE_MDAT,    16'd0, 8'h00, 1'b0, 48'd43},
    '{32'd7,         TYPE_TRAF,    16'd0, 8'h00, 1'b1, 48'd51},
    '{32'd1,         TYPE_MOOF,    16'd0, 8'h00, 1'b1, 48'd59}
  };

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [OFFSET_W-1:0] total_length = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [7:0]          data_byte = '0;
  logic                out_valid;
  logic                out_ready = 1'b1;
  logic [1:0]          kind;
  logic [WORD_W-1:0]   type_code;
  logic [WORD_W-1:0]   declared_size;
  logic [OFFSET_W-1:0] box_offset;
  logic [7:0]          payload_byte;
  logic                last_payload;
  logic                short_size;

  mp4_box_header_walker u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .total_length  (total_length),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .type_code     (type_code),
    .declared_size (declared_size),
    .box_offset    (box_offset),
    .payload_byte  (payload_byte),
    .last_payload  (last_payload),
    .short_size    (short_size)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // walk state of the predictor
  logic [OFFSET_W-1:0] len_cfg = '0;
  logic [OFFSET_W-1:0] off_now = '0;
  logic [63:0]         hdr_word = '0;
  logic [2:0]          hdr_cnt = '0;
  logic [OFFSET_W-1:0] start_off = '0;
  logic [WORD_W-1:0]   remain = '0;
  walk_mode_t          walk_state = MODE_HEADER;
  bit                  walk_done = 1'b0;

  result_t     box_reports_q [$];
  bit          hdr_typed = 1'b0;
  result_t     hdr_value = '0;
  bit          idle_on = 1'b1;
  int unsigned stall_cnt = 0;
  int unsigned cycles = 0;
  int unsigned err_cnt = 0;
  int unsigned bytes_sent = 0;
  int unsigned n_checked = 0;
  int unsigned n_hdr = 0;
  int unsigned n_pay = 0;
  int unsigned n_end = 0;

  task automatic report(input string msg);
    $display("ERROR cycle %0d: %s", cycles, msg);
    err_cnt++;
  endtask

  function automatic bit walk_byte(input logic [7:0] b, output result_t r);
    logic [WORD_W-1:0] sz;
    logic [WORD_W-1:0] ty;
    logic [WORD_W-1:0] plen;
    bit                got;
    r = '0;
    got = 1'b0;
    if (walk_done) return 1'b0;
    sz = hdr_word[63:32];
    ty = hdr_word[31:0];
    case (walk_state)
      MODE_MDAT: begin
        r.kind = KIND_PAYLOAD;
        r.type_code = ty;
        r.declared_size = sz;
        r.box_offset = start_off;
        r.payload_byte = b;
        r.last_payload = (remain == 1);
        r.short_size = (sz < HDR_LEN);
        got = 1'b1;
        remain = remain - 32'd1;
        if (remain == 0) walk_state = MODE_HEADER;
      end
      MODE_SKIP: begin
        remain = remain - 32'd1;
        if (remain == 0) walk_state = MODE_HEADER;
      end
      default: begin
        if (hdr_cnt == 0) begin
          if (len_cfg >= MIN_TAIL && off_now >= len_cfg - MIN_TAIL) begin
            walk_done = 1'b1;
            r.kind = KIND_END;
            r.box_offset = off_now;
            return 1'b1;
          end
          start_off = off_now;
        end
        hdr_word = {hdr_word[55:0], b};
        hdr_cnt = hdr_cnt + 3'd1;
        if (hdr_cnt == 0) begin
          sz = hdr_word[63:32];
          ty = hdr_word[31:0];
          plen = sz - HDR_LEN;
          r.kind = KIND_HEADER;
          r.type_code = ty;
          r.declared_size = sz;
          r.box_offset = start_off;
          r.short_size = (sz < HDR_LEN);
          got = 1'b1;
          if (ty == TYPE_MOOF || ty == TYPE_TRAF || plen == 0) begin
            walk_state = MODE_HEADER;
          end else begin
            remain = plen;
            walk_state = (ty == TYPE_MDAT) ? MODE_MDAT : MODE_SKIP;
          end
        end
      end
    endcase
    off_now = off_now + 48'd1;
    return got;
  endfunction

  always @(posedge clk) begin : monitor
    result_t pred;
    result_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        if (walk_byte(data_byte, pred))
          box_reports_q.insert(box_reports_q.size(), hdr_typed ? hdr_value : pred);
      end
      if (out_valid && out_ready) begin
        if (box_reports_q.size() == 0) begin
          report($sformatf("unexpected result kind %0d offset %0h", kind, box_offset));
        end else begin
          want = box_reports_q.pop_front();
          n_checked++;
          if (want.kind == KIND_HEADER) n_hdr++;
          else if (want.kind == KIND_PAYLOAD) n_pay++;
          else n_end++;
          if (kind !== want.kind)
            report($sformatf("kind %0d, want %0d", kind, want.kind));
          if (type_code !== want.type_code)
            report($sformatf("type_code %0h, want %0h", type_code, want.type_code));
          if (declared_size !== want.declared_size)
            report($sformatf("declared_size %0h, want %0h", declared_size,
                             want.declared_size));
          if (box_offset !== want.box_offset)
            report($sformatf("box_offset %0h, want %0h", box_offset, want.box_offset));
          if (payload_byte !== want.payload_byte)
            report($sformatf("payload_byte %0h, want %0h", payload_byte, want.payload_byte));
          if (last_payload !== want.last_payload)
            report($sformatf("last_payload %0b, want %0b", last_payload, want.last_payload));
          if (short_size !== want.short_size)
            report($sformatf("short_size %0b, want %0b", short_size, want.short_size));
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!idle_on) begin
      stall_cnt <= 0;
      out_ready <= 1'b1;
    end else if (stall_cnt != 0) begin
      stall_cnt <= stall_cnt - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_cnt <= $urandom_range(0, 14);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      report("timeout");
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit typed, input result_t t);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    hdr_typed <= typed;
    hdr_value <= t;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_box(input logic [WORD_W-1:0] size, input logic [WORD_W-1:0] btype,
                          input int unsigned plen, input bit typed, input result_t t,
                          input logic [7:0] fill, input bit rnd);
    logic [63:0] hdr;
    hdr = {size, btype};
    for (int i = 0; i < 8; i++) send_byte(hdr[63-8*i -: 8], typed && i == 7, t);
    for (int i = 0; i < plen; i++) send_byte(rnd ? 8'($urandom) : fill ^ 8'(i), 1'b0, t);
  endtask

  task automatic send_random_box();
    int unsigned       pick;
    int unsigned       plen;
    logic [WORD_W-1:0] ty;
    logic [WORD_W-1:0] sz;
    result_t           none;
    none = '0;
    pick = $urandom_range(0, 99);
    plen = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300) : $urandom_range(0, 24);
    if (pick < 35) begin
      ty = TYPE_MDAT;
      sz = HDR_LEN + plen;
    end else if (pick < 60) begin
      do ty = $urandom; while (ty == TYPE_MOOF || ty == TYPE_TRAF);
      sz = HDR_LEN + plen;
    end else if (pick < 85) begin
      ty = $urandom_range(0, 1) ? TYPE_MOOF : TYPE_TRAF;
      case ($urandom_range(0, 2))
        0: sz = $urandom_range(0, 7);
        1: sz = $urandom;
        default: sz = HDR_LEN + plen;
      endcase
      plen = 0;
    end else begin
      ty = $urandom;
      sz = HDR_LEN;
      plen = 0;
    end
    send_box(sz, ty, plen, 1'b0, none, 8'h00, 1'b1);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (box_reports_q.size() != 0) @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [OFFSET_W-1:0] v);
    settle();
    cfg_valid <= 1'b1;
    total_length <= v;
    do @(posedge clk); while (!cfg_ready);
    len_cfg = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    result_t hdr_exp;
    result_t none;
    none = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    cfg_write('0);
    foreach (DIR_ROWS[i]) begin
      hdr_exp = '0;
      hdr_exp.kind = KIND_HEADER;
      hdr_exp.type_code = DIR_ROWS[i].btype;
      hdr_exp.declared_size = DIR_ROWS[i].size;
      hdr_exp.box_offset = DIR_ROWS[i].at;
      hdr_exp.short_size = DIR_ROWS[i].short_flag;
      send_box(DIR_ROWS[i].size, DIR_ROWS[i].btype, int'(DIR_ROWS[i].plen), 1'b1, hdr_exp,
               DIR_ROWS[i].fill, 1'b0);
    end
    while (bytes_sent < 200) send_random_box();

    cfg_write(48'd8);
    while (bytes_sent < 350) send_random_box();

    cfg_write(48'hFFFF_FFFF_FFFF);
    while (bytes_sent < 500) send_random_box();

    cfg_write({16'($urandom_range(1, 16'hFFFF)), 32'($urandom)});
    while (bytes_sent < 600) send_random_box();

    // arm the end test a little past the current offset, no idling from here
    idle_on = 1'b0;
    cfg_write(off_now + MIN_TAIL + 48'($urandom_range(20, 120)));
    while (!walk_done) send_random_box();
    repeat (10) send_byte(8'($urandom), 1'b0, none);
    settle();

    if (box_reports_q.size() != 0)
      report($sformatf("%0d expected results never arrived", box_reports_q.size()));
    $display("Walked %0d file bytes under five total_length settings, %0d results checked",
             bytes_sent, n_checked);
    $display("  %0d box headers, %0d mdat payload bytes, %0d end-of-file reports",
             n_hdr, n_pay, n_end);
    if (err_cnt == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
